>>> rtl/bwrg_pkg.sv
// Shared types and constants for the bitmap word run grouper.
// No dependencies; used by every module under rtl/.
package bwrg_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_WORDS_DEF = 67108864;

  localparam int DATA_W = 64;   // block_word / chunk_word
  localparam int LEN_W  = 33;   // chunk_length
  localparam int VB_W   = 7;    // valid_bits

  localparam int IN_TDATA_W  = 72;   // 64 + 7, padded to bytes
  localparam int OUT_TDATA_W = 104;  // 64 + 33, padded to bytes

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              fin;
  } bwrg_chunk_t;

endpackage

>>> rtl/bitmap_word_run_grouper.sv
// Top level of the bitmap word run grouper.
// Depends on bwrg_pkg, bwrg_core and bwrg_fifo.
//
// Usage:
//   in_*  : one 64-bit bitmap word per transfer; in_tlast marks the final
//           word, whose valid bit count rides in in_tdata[70:64].
//   out_* : chunks (word plus bit length); out_tlast marks the last chunk
//           of a bitmap. Uniform words merge into one run chunk.
// Throughput: one word per cycle while the queue has room for two chunks; a
//   word that yields two chunks pushes both in the same cycle. The output
//   drains one chunk per cycle, so the output side bounds sustained rate.
// Path from input word to its chunks on out_*: the input register, then the
//   four-entry chunk queue.
// A word leaves the input register only when the queue has room for two
//   chunks, so a stalled receiver backs up into in_tready without loss.
// Reset (rst_n low, synchronous) empties the queue and drops any pending run.
module bitmap_word_run_grouper #(
  parameter int WORD_BITS = bwrg_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = bwrg_pkg::MAX_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] block_word, [70:64] valid_bits, [71] zero
  input  logic [bwrg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] chunk_word, [96:64] chunk_length, [103:97] zero
  output logic [bwrg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);
  import bwrg_pkg::*;

  logic              hold_v_r;
  logic [DATA_W-1:0] hold_word_r;
  logic [VB_W-1:0]   hold_valid_r;
  logic              hold_fin_r;
  logic              room2;
  logic              fire;
  logic [1:0]        res_n;
  logic [1:0]        push_n;
  bwrg_chunk_t       res0, res1, head;

  assign fire      = hold_v_r && room2;
  assign in_tready = !hold_v_r || room2;
  assign push_n    = fire ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tready) begin
      hold_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hold_word_r  <= in_tdata[DATA_W-1:0];
      hold_valid_r <= in_tdata[DATA_W +: VB_W];
      hold_fin_r   <= in_tlast;
    end
  end

  bwrg_core #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .blk_word  (hold_word_r),
    .blk_fin   (hold_fin_r),
    .blk_valid (hold_valid_r),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  bwrg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {(OUT_TDATA_W - DATA_W - LEN_W)'(0), head.len, head.word};
  assign out_tlast = head.fin;

endmodule

>>> rtl/bwrg_core.sv
// Run detection and merge logic plus the pending-run state registers.
// Depends on bwrg_pkg. Produces up to two chunks per word.
module bwrg_core #(
  parameter int WORD_BITS = bwrg_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = bwrg_pkg::MAX_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [bwrg_pkg::DATA_W-1:0] blk_word,
  input  logic                        blk_fin,
  input  logic [bwrg_pkg::VB_W-1:0]   blk_valid,
  output logic [1:0]                  res_n,
  output bwrg_pkg::bwrg_chunk_t       res0,
  output bwrg_pkg::bwrg_chunk_t       res1
);
  import bwrg_pkg::*;

  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'(longint'(MAX_WORDS) * longint'(WORD_BITS));
  localparam logic [DATA_W-1:0] WMASK =
    DATA_W'((65'd1 << WORD_BITS) - 65'd1);
  localparam logic [VB_W-1:0] WB_V = VB_W'(WORD_BITS);

  logic              run_active_r, run_active_nxt;
  logic [DATA_W-1:0] run_word_r, run_word_nxt;
  logic [LEN_W-1:0]  run_len_r, run_len_nxt;

  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] vmask;
  logic [VB_W-1:0]   vcnt;
  logic              uniform;
  logic              fin_match;
  logic [LEN_W:0]    sum;
  logic [LEN_W-1:0]  sum_sat;

  always_comb begin
    word    = blk_word & WMASK;
    uniform = (word == '0) || (word == WMASK);
    vcnt    = (blk_valid == '0 || blk_valid > WB_V) ? WB_V : blk_valid;
    vmask   = DATA_W'((65'd1 << vcnt) - 65'd1);
    fin_match = run_active_r && (((word ^ run_word_r) & vmask) == '0);
    // one adder serves both the final extend and the plain extend
    sum     = {1'b0, run_len_r} + (LEN_W+1)'(blk_fin ? vcnt : WB_V);
    sum_sat = (sum > {1'b0, LEN_CAP}) ? LEN_CAP : sum[LEN_W-1:0];
  end

  always_comb begin
    res_n          = 2'd0;
    res0           = '{word: run_word_r, len: run_len_r, fin: 1'b0};
    res1           = '{word: word, len: LEN_W'(WORD_BITS), fin: 1'b0};
    run_active_nxt = run_active_r;
    run_word_nxt   = run_word_r;
    run_len_nxt    = run_len_r;
    if (blk_fin) begin
      run_active_nxt = 1'b0;
      run_word_nxt   = '0;
      run_len_nxt    = '0;
      if (fin_match) begin
        res_n = 2'd1;
        res0  = '{word: run_word_r, len: sum_sat, fin: 1'b1};
      end else if (run_active_r) begin
        res_n = 2'd2;
        res1  = '{word: word, len: LEN_W'(vcnt), fin: 1'b1};
      end else begin
        res_n = 2'd1;
        res0  = '{word: word, len: LEN_W'(vcnt), fin: 1'b1};
      end
    end else if (run_active_r && word == run_word_r) begin
      run_len_nxt = sum_sat;
    end else begin
      // run (if any) goes out first, then either a new run or a literal
      if (uniform) begin
        res_n          = run_active_r ? 2'd1 : 2'd0;
        run_active_nxt = 1'b1;
        run_word_nxt   = word;
        run_len_nxt    = LEN_W'(WORD_BITS);
      end else begin
        run_active_nxt = 1'b0;
        run_word_nxt   = '0;
        run_len_nxt    = '0;
        if (run_active_r) begin
          res_n = 2'd2;
        end else begin
          res_n = 2'd1;
          res0  = res1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      run_word_r   <= '0;
      run_len_r    <= '0;
    end else if (fire) begin
      run_active_r <= run_active_nxt;
      run_word_r   <= run_word_nxt;
      run_len_r    <= run_len_nxt;
    end
  end

endmodule

>>> rtl/bwrg_fifo.sv
// Four-entry chunk queue: up to two pushes and one pop per cycle.
// Depends on bwrg_pkg for the chunk type.
module bwrg_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  bwrg_pkg::bwrg_chunk_t push0,
  input  bwrg_pkg::bwrg_chunk_t push1,
  output logic                  room2,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output bwrg_pkg::bwrg_chunk_t pop_data
);
  import bwrg_pkg::*;

  localparam int DEPTH = 4;

  bwrg_chunk_t mem_r [DEPTH];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != 3'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= 3'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
